>>> rtl/mpbsd_pkg.sv
// Package for the multi-pattern bit sequence detector.
// Holds sizes, register indexes and default parameters; no dependencies.
`default_nettype none

package mpbsd_pkg;

  localparam int MaxPatternLen = 16;
  localparam int PatternSlots  = 3;

  localparam int PatBitsW = 16;
  localparam int PatLenW  = 5;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CfgOutputMode = 3'd0,
    CfgPatABits   = 3'd1,
    CfgPatALen    = 3'd2,
    CfgPatBBits   = 3'd3,
    CfgPatBLen    = 3'd4,
    CfgPatCBits   = 3'd5,
    CfgPatCLen    = 3'd6
  } cfg_reg_e;

  typedef enum logic {
    ModeMoore = 1'b0,
    ModeMealy = 1'b1
  } out_mode_e;

endpackage

`default_nettype wire

>>> rtl/multi_pattern_bit_sequence_detector.sv
// Overlapping serial sequence detector with up to three configurable patterns.
// Depends on mpbsd_pkg.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------
//  in      | input     | in_valid_i / in_stall_o   | in_bit_i
//  out     | output    | out_valid_o / out_stall_i | out_detect_o
//  cfg     | input     | cfg_we_i (no wait)        | cfg_index_i, cfg_data_i
//
// One transaction per cycle unless stalled; the result follows in the next cycle.
// The pattern compare is one masked compare per slot in front of the result register.
// Reset clears the history, the fill count, the registers and the output valid.
// in_stall_o is high only while a result is held and out_stall_i is high.
`default_nettype none

module multi_pattern_bit_sequence_detector #(
  parameter int MAX_PATTERN_LEN = mpbsd_pkg::MaxPatternLen,
  parameter int PATTERN_SLOTS   = mpbsd_pkg::PatternSlots
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [mpbsd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [mpbsd_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic                           in_bit_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic                                out_detect_o
);

  localparam int FillW = $clog2(MAX_PATTERN_LEN + 1);
  localparam int LW    = (FillW > mpbsd_pkg::PatLenW) ? FillW : mpbsd_pkg::PatLenW;
  localparam int PW    = (MAX_PATTERN_LEN > mpbsd_pkg::PatBitsW) ?
                         MAX_PATTERN_LEN : mpbsd_pkg::PatBitsW;

  mpbsd_pkg::out_mode_e                mode_q;
  logic [mpbsd_pkg::PatBitsW-1:0]      pat_bits_q [PATTERN_SLOTS];
  logic [mpbsd_pkg::PatLenW-1:0]       pat_len_q  [PATTERN_SLOTS];
  logic [MAX_PATTERN_LEN-1:0]          hist_q, hist_d;
  logic [FillW-1:0]                    fill_q, fill_d;
  logic                                out_valid_q, out_valid_d;
  logic                                detect_q, detect_d;

  logic                                in_accept;
  logic [1:0]                          wr_slot;
  mpbsd_pkg::cfg_reg_e                 cfg_reg;
  logic [MAX_PATTERN_LEN-1:0]          chk_hist;
  logic [LW-1:0]                       chk_fill;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_detect_o = detect_q;

  assign cfg_reg = mpbsd_pkg::cfg_reg_e'(cfg_index_i);
  assign wr_slot = 2'((cfg_index_i - 3'd1) >> 1);

  assign hist_d = {hist_q[MAX_PATTERN_LEN-2:0], in_bit_i};
  assign fill_d = (fill_q == FillW'(MAX_PATTERN_LEN)) ? fill_q : fill_q + FillW'(1);

  always_comb begin
    if (mode_q == mpbsd_pkg::ModeMealy) begin
      chk_hist = hist_d;
      chk_fill = LW'(fill_d);
    end else begin
      chk_hist = hist_q;
      chk_fill = LW'(fill_q);
    end
  end

  always_comb begin
    logic [LW-1:0] len_eff;
    logic [PW-1:0] pat_w;
    logic          diff;
    detect_d = 1'b0;
    for (int s = 0; s < PATTERN_SLOTS; s++) begin
      len_eff = (LW'(pat_len_q[s]) > LW'(MAX_PATTERN_LEN)) ?
                LW'(MAX_PATTERN_LEN) : LW'(pat_len_q[s]);
      pat_w = PW'(pat_bits_q[s]);
      diff  = 1'b0;
      for (int k = 0; k < MAX_PATTERN_LEN; k++) begin
        if (LW'(k) < len_eff) begin
          diff = diff | (chk_hist[k] ^ pat_w[k]);
        end
      end
      if ((len_eff != '0) && (chk_fill >= len_eff) && !diff) begin
        detect_d = 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= mpbsd_pkg::ModeMoore;
      for (int s = 0; s < PATTERN_SLOTS; s++) begin
        pat_bits_q[s] <= '0;
        pat_len_q[s]  <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_reg)
        mpbsd_pkg::CfgOutputMode: begin
          mode_q <= mpbsd_pkg::out_mode_e'(cfg_data_i[0]);
        end
        mpbsd_pkg::CfgPatABits, mpbsd_pkg::CfgPatBBits, mpbsd_pkg::CfgPatCBits: begin
          for (int s = 0; s < PATTERN_SLOTS; s++) begin
            if (wr_slot == 2'(s)) begin
              pat_bits_q[s] <= cfg_data_i[mpbsd_pkg::PatBitsW-1:0];
            end
          end
        end
        mpbsd_pkg::CfgPatALen, mpbsd_pkg::CfgPatBLen, mpbsd_pkg::CfgPatCLen: begin
          for (int s = 0; s < PATTERN_SLOTS; s++) begin
            if (wr_slot == 2'(s)) begin
              pat_len_q[s] <= cfg_data_i[mpbsd_pkg::PatLenW-1:0];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q      <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_accept) begin
        hist_q <= hist_d;
        fill_q <= fill_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      detect_q <= detect_d;
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(MAX_PATTERN_LEN))
    else $error("fill count above history length");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> out_valid_o)
    else $error("accepted transaction gave no result");

  a_hist_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> hist_q[0] == $past(in_bit_i))
    else $error("history did not take the accepted bit");

  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && fill_q != FillW'(MAX_PATTERN_LEN)) |=> fill_q == $past(fill_q) + FillW'(1))
    else $error("fill count did not advance");

endmodule

`default_nettype wire

>>> tb/mpbsd_checker.sv
`timescale 1ns / 1ps
// Checker for the multi-pattern bit sequence detector: tracks register writes,
// predicts the detect flag of every accepted bit and compares it with the output.
// Depends on mpbsd_pkg.

module mpbsd_checker
  import mpbsd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic                in_bit_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic                out_detect_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  out_mode_e                  mode;
  logic [PatBitsW-1:0]        pat_bits [PatternSlots];
  logic [PatLenW-1:0]         pat_len  [PatternSlots];
  logic [MaxPatternLen-1:0]   history;
  logic [PatLenW-1:0]         fill;
  logic                       detect_q [$];
  int                         mismatches = 0;

  assign fail_count_o = mismatches;

  function automatic logic pattern_hit(input logic [MaxPatternLen-1:0] hist,
                                       input logic [PatLenW-1:0] valid_bits);
    int          s;
    int          n;
    logic [31:0] mask;
    pattern_hit = 1'b0;
    for (s = 0; s < PatternSlots; s++) begin
      n = (pat_len[s] > MaxPatternLen) ? MaxPatternLen : int'(pat_len[s]);
      mask = (32'd1 << n) - 32'd1;
      if (n != 0 && int'(valid_bits) >= n &&
          ((32'(hist) ^ 32'(pat_bits[s])) & mask) == 32'd0) begin
        pattern_hit = 1'b1;
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [MaxPatternLen-1:0] next_hist;
    logic [PatLenW-1:0]       next_fill;
    logic                     exp_detect;
    if (!rst_ni) begin
      mode = ModeMoore;
      for (int s = 0; s < PatternSlots; s++) begin
        pat_bits[s] = '0;
        pat_len[s]  = '0;
      end
      history = '0;
      fill    = '0;
      detect_q.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (detect_q.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: unexpected detect transaction %0b", $time, out_detect_i);
          end
          mismatches++;
        end else begin
          exp_detect = detect_q.pop_front();
          if (out_detect_i !== exp_detect) begin
            if (mismatches < 10) begin
              $display("%0t: detect mismatch: expected %0b, got %0b",
                       $time, exp_detect, out_detect_i);
            end
            mismatches++;
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        next_hist = {history[MaxPatternLen-2:0], in_bit_i};
        next_fill = (fill < MaxPatternLen) ? fill + 1'b1 : fill;
        if (mode == ModeMealy) begin
          detect_q.push_back(pattern_hit(next_hist, next_fill));
        end else begin
          detect_q.push_back(pattern_hit(history, fill));
        end
        history = next_hist;
        fill    = next_fill;
      end

      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgOutputMode: mode = out_mode_e'(cfg_data_i[0]);
          CfgPatABits:   pat_bits[0] = cfg_data_i;
          CfgPatALen:    pat_len[0]  = cfg_data_i[PatLenW-1:0];
          CfgPatBBits:   pat_bits[1] = cfg_data_i;
          CfgPatBLen:    pat_len[1]  = cfg_data_i[PatLenW-1:0];
          CfgPatCBits:   pat_bits[2] = cfg_data_i;
          CfgPatCLen:    pat_len[2]  = cfg_data_i[PatLenW-1:0];
          default: ;
        endcase
      end

      pending_o <= detect_q.size();
    end
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Top of the detector testbench: clock, reset, register setup, bit stimulus,
// output stall pattern and verdict. Depends on mpbsd_pkg and mpbsd_checker.

module testbench;
  import mpbsd_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgBadIdx = 3'd7;
  localparam int HoldOff   = 200;
  localparam int IdleLimit = 3000;
  localparam int NumPhases = 20;
  localparam int PhaseLen  = 100;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;
  logic                in_valid  = 1'b0;
  logic                in_bit    = 1'b0;
  logic                out_stall = 1'b0;
  logic                in_stall;
  logic                out_valid;
  logic                out_detect;
  int                  fail_count;
  int                  pending;

  bit                  quiet    = 1'b0;
  bit                  hold_req = 1'b0;
  int                  items_sent = 0;
  int                  idle_cycles = 0;
  logic [PatBitsW-1:0] slot_bits [PatternSlots];
  int                  slot_len  [PatternSlots];

  multi_pattern_bit_sequence_detector DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .in_bit_i     (in_bit),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .out_detect_o (out_detect)
  );

  mpbsd_checker checker_inst (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_bit_i     (in_bit),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_detect_i (out_detect),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IdleLimit) begin
      $display("multi_pattern_bit_sequence_detector test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin : receiver
    bit hold;
    int len;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold = 1'b1;
        len = HoldOff;
      end else if (quiet) begin
        hold = 1'b0;
        len = 1;
      end else begin
        hold = ($urandom_range(0, 2) == 0);
        len = idle_len() + 1;
      end
      out_stall <= hold;
      repeat (len) @(posedge clk);
    end
  end

  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [CfgDataW-1:0] mode_d,
                               input logic [CfgDataW-1:0] a_bits, a_len,
                               input logic [CfgDataW-1:0] b_bits, b_len,
                               input logic [CfgDataW-1:0] c_bits, c_len,
                               input bit bad_write);
    write_cfg(CfgOutputMode, mode_d);
    write_cfg(CfgPatABits, a_bits);
    write_cfg(CfgPatALen, a_len);
    write_cfg(CfgPatBBits, b_bits);
    write_cfg(CfgPatBLen, b_len);
    write_cfg(CfgPatCBits, c_bits);
    write_cfg(CfgPatCLen, c_len);
    if (bad_write) write_cfg(CfgBadIdx, CfgDataW'($urandom));
    cfg_we <= 1'b0;
    slot_bits[0] = a_bits;
    slot_bits[1] = b_bits;
    slot_bits[2] = c_bits;
    slot_len[0] = (a_len[PatLenW-1:0] > MaxPatternLen) ? MaxPatternLen : a_len[PatLenW-1:0];
    slot_len[1] = (b_len[PatLenW-1:0] > MaxPatternLen) ? MaxPatternLen : b_len[PatLenW-1:0];
    slot_len[2] = (c_len[PatLenW-1:0] > MaxPatternLen) ? MaxPatternLen : c_len[PatLenW-1:0];
    @(posedge clk);
  endtask

  function automatic logic [CfgDataW-1:0] rand_pattern();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return CfgDataW'($urandom);
  endfunction

  function automatic logic [CfgDataW-1:0] rand_length();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return CfgDataW'(MaxPatternLen);
    if (r == 2) return CfgDataW'($urandom_range(MaxPatternLen + 1, 31));
    if (r == 3) begin
      return CfgDataW'($urandom_range(0, 31) | ($urandom_range(1, 2047) << PatLenW));
    end
    if (r < 12) return CfgDataW'($urandom_range(1, 6));
    return CfgDataW'($urandom_range(7, MaxPatternLen));
  endfunction

  task automatic send_bit(input logic b);
    int gap;
    in_valid <= 1'b1;
    in_bit   <= b;
    do @(posedge clk); while (in_stall);
    items_sent++;
    gap = quiet ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // oldest pattern bit first; a broken copy has one bit flipped
  task automatic send_pattern(input logic [PatBitsW-1:0] bits, input int n, input bit broken);
    int flip;
    int i;
    flip = broken ? $urandom_range(0, n - 1) : -1;
    for (i = n - 1; i >= 0; i--) send_bit(bits[i] ^ (i == flip));
  endtask

  task automatic run_stream(input int quota);
    int start;
    int s;
    start = items_sent;
    while (items_sent - start < quota) begin
      s = $urandom_range(0, PatternSlots - 1);
      if ($urandom_range(0, 9) < 6 && slot_len[s] > 0) begin
        send_pattern(slot_bits[s], slot_len[s], $urandom_range(0, 3) == 0);
      end else begin
        repeat ($urandom_range(1, 4)) send_bit(1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic finish_phase();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  initial begin : stimulus
    int phase;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // all-zero pattern against a short history, high bits above the length,
    // an overlong length and a write to an unmapped index
    apply_setting(16'h0001, 16'h0000, 16'd16, 16'hFFFD, 16'd2, 16'hFFFF, 16'd31, 1'b1);
    repeat (17) send_bit(1'b0);
    send_bit(1'b1);
    send_bit(1'b0);
    send_bit(1'b1);
    send_bit(1'b1);
    finish_phase();

    // Moore output with two disabled slots
    apply_setting(16'hFFFE, 16'h0001, 16'd0, 16'hFFFE, 16'd1, 16'h0000, 16'd0, 1'b0);
    send_bit(1'b1);
    send_bit(1'b0);
    send_bit(1'b0);
    send_bit(1'b1);
    finish_phase();

    for (phase = 0; phase < NumPhases; phase++) begin
      quiet = (phase % 5 == 4);
      apply_setting(CfgDataW'($urandom), rand_pattern(), rand_length(), rand_pattern(),
                    rand_length(), rand_pattern(), rand_length(),
                    $urandom_range(0, 2) == 0);
      if (phase == 2) hold_req = 1'b1;
      run_stream(PhaseLen);
      finish_phase();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("multi_pattern_bit_sequence_detector test passed");
    end else begin
      $display("multi_pattern_bit_sequence_detector test failed");
    end
    $finish;
  end

endmodule
